FILE: rtl/tsfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsfa_pkg
// Types and constants shared by the time sync frame assembler modules.
// ----------------------------------------------------------------------------
package tsfa_pkg;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_ECHO    = 3'd1,
        CMD_DAY     = 3'd2,
        CMD_HOUR    = 3'd3,
        CMD_MINUTE  = 3'd4,
        CMD_SECONDS = 3'd5,
        CMD_OFFSET  = 3'd6,
        CMD_UNUSED  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_WINDOW  = 2'd0,
        CFG_DELAY   = 2'd1,
        CFG_INVALID = 2'd2,
        CFG_NONE    = 2'd3
    } t_cfg_index;

    localparam logic [1:0] REPLY_PONG  = 2'd0;
    localparam logic [1:0] REPLY_ACK   = 2'd1;
    localparam logic [1:0] REPLY_DELTA = 2'd2;

    localparam logic       KIND_SET   = 1'b0;
    localparam logic       KIND_REPLY = 1'b1;

    localparam logic [2:0] HAVE_DAY    = 3'b001;
    localparam logic [2:0] HAVE_HOUR   = 3'b010;
    localparam logic [2:0] HAVE_MINUTE = 3'b100;
    localparam logic [2:0] HAVE_ALL    = 3'b111;

    localparam logic [7:0] DAY_MIN     = 8'd1;
    localparam logic [7:0] DAY_MAX     = 8'd31;
    localparam logic [7:0] HOUR_MAX    = 8'd23;
    localparam logic [7:0] SEC_MAX     = 8'd59;
    localparam logic [15:0] AGE_MAX    = 16'hFFFF;

    localparam logic [15:0] WINDOW_RESET  = 16'd3000;
    localparam logic [9:0]  DELAY_RESET   = 10'd200;
    localparam logic [7:0]  INVALID_RESET = 8'd128;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] param;
        logic       clock_valid;
        logic [5:0] clock_second;
    } t_item;

    typedef struct packed {
        logic [15:0] window_ticks;
        logic [9:0]  reply_delay_ticks;
        logic [7:0]  delta_invalid_code;
    } t_cfg;

    typedef struct packed {
        logic       result_kind;
        logic [4:0] set_day;
        logic [4:0] set_hour;
        logic [5:0] set_minute;
        logic [5:0] set_second;
        logic [1:0] reply_code;
        logic [7:0] reply_byte;
    } t_result;

    // circular offset master - local, folded into -30..30; invalid_code if not valid or out of range
    function automatic logic [7:0] delta_byte(
        input logic [7:0] master,
        input logic       valid,
        input logic [5:0] local_sec,
        input logic [7:0] invalid_code
    );
        logic signed [7:0] d;
        d = $signed(master) - $signed({2'b00, local_sec});
        if (!valid || master > SEC_MAX || {2'b00, local_sec} > SEC_MAX) begin
            return invalid_code;
        end
        if (d > 8'sd30) begin
            d = d - 8'sd60;
        end else if (d < -8'sd30) begin
            d = d + 8'sd60;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tsfa_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsfa_core
// Frame buffer, age counter and reply slot; one word processed per fire.
// ----------------------------------------------------------------------------
module tsfa_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  tsfa_pkg::t_item       i_item,
    input  tsfa_pkg::t_cfg        i_cfg,
    output logic                  o_res_valid,
    output tsfa_pkg::t_result     o_res
);
    import tsfa_pkg::*;

    logic [4:0]  r_day,     n_day;
    logic [4:0]  r_hour,    n_hour;
    logic [5:0]  r_minute,  n_minute;
    logic [2:0]  r_have,    n_have;
    logic [15:0] r_age,     n_age;
    logic        r_pending, n_pending;
    logic [1:0]  r_code,    n_code;
    logic [7:0]  r_byte,    n_byte;
    logic [9:0]  r_cd,      n_cd;

    logic [9:0]  cd_dec;
    logic [15:0] age_inc;

    always_comb begin
        n_day     = r_day;
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_have    = r_have;
        n_age     = r_age;
        n_pending = r_pending;
        n_code    = r_code;
        n_byte    = r_byte;
        n_cd      = r_cd;
        o_res_valid = 1'b0;
        o_res       = '0;
        cd_dec  = (r_cd != 10'd0) ? r_cd - 10'd1 : r_cd;
        age_inc = (r_age < AGE_MAX) ? r_age + 16'd1 : r_age;

        unique case (i_item.command)
            CMD_TICK: begin
                n_cd = cd_dec;
                if (r_pending && cd_dec == 10'd0) begin
                    o_res_valid      = 1'b1;
                    o_res.result_kind = KIND_REPLY;
                    o_res.reply_code = r_code;
                    o_res.reply_byte = r_byte;
                    n_pending = 1'b0;
                    n_code    = 2'd0;
                    n_byte    = 8'd0;
                end
                if (r_have != 3'b000) begin
                    n_age = age_inc;
                    if (age_inc > i_cfg.window_ticks) begin
                        n_have = 3'b000;
                    end
                end
            end
            CMD_ECHO: begin
                n_pending = 1'b1;
                n_code    = REPLY_PONG;
                n_byte    = 8'd0;
                n_cd      = i_cfg.reply_delay_ticks;
            end
            CMD_DAY: begin
                if (i_item.param >= DAY_MIN && i_item.param <= DAY_MAX) begin
                    n_day  = i_item.param[4:0];
                    n_have = HAVE_DAY;
                    n_age  = 16'd0;
                end
            end
            CMD_HOUR: begin
                if (i_item.param <= HOUR_MAX) begin
                    n_hour = i_item.param[4:0];
                    if ((r_have & HAVE_DAY) == 3'b000) begin
                        n_age = 16'd0;
                    end
                    n_have = r_have | HAVE_HOUR;
                end
            end
            CMD_MINUTE: begin
                if (i_item.param <= SEC_MAX) begin
                    n_minute = i_item.param[5:0];
                    if ((r_have & (HAVE_DAY | HAVE_HOUR)) == 3'b000) begin
                        n_age = 16'd0;
                    end
                    n_have = r_have | HAVE_MINUTE;
                end
            end
            CMD_SECONDS: begin
                if (r_have == HAVE_ALL && i_item.param <= SEC_MAX) begin
                    o_res_valid       = 1'b1;
                    o_res.result_kind = KIND_SET;
                    o_res.set_day     = r_day;
                    o_res.set_hour    = r_hour;
                    o_res.set_minute  = r_minute;
                    o_res.set_second  = i_item.param[5:0];
                    n_pending = 1'b1;
                    n_code    = REPLY_ACK;
                    n_byte    = 8'd0;
                    n_cd      = i_cfg.reply_delay_ticks;
                end
                n_have = 3'b000;
            end
            CMD_OFFSET: begin
                n_pending = 1'b1;
                n_code    = REPLY_DELTA;
                n_byte    = delta_byte(i_item.param, i_item.clock_valid,
                                       i_item.clock_second, i_cfg.delta_invalid_code);
                n_cd      = i_cfg.reply_delay_ticks;
            end
            CMD_UNUSED: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day     <= '0;
            r_hour    <= '0;
            r_minute  <= '0;
            r_have    <= '0;
            r_age     <= '0;
            r_pending <= 1'b0;
            r_code    <= '0;
            r_byte    <= '0;
            r_cd      <= '0;
        end else if (i_fire) begin
            r_day     <= n_day;
            r_hour    <= n_hour;
            r_minute  <= n_minute;
            r_have    <= n_have;
            r_age     <= n_age;
            r_pending <= n_pending;
            r_code    <= n_code;
            r_byte    <= n_byte;
            r_cd      <= n_cd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/time_sync_frame_assembler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_sync_frame_assembler
// Parks day/hour/minute frames, applies full time on a seconds frame and
// sends delayed pong, acknowledge and delta replies.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | command, param, clock_valid,
//          |           |                         | clock_second
//  out     | output    | o_out_valid/i_out_stall | result_kind, set_*, reply_*
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one word per cycle while no result stalls; a word is registered, processed
//  against the buffer state and its result registered
//  synchronous active-low reset clears control state and loads register defaults
//  a stalled result holds the processing stage; the input register still
//  takes one word while the result waits
// ----------------------------------------------------------------------------
module time_sync_frame_assembler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_param,
    input  wire logic        i_clock_valid,
    input  wire logic [5:0]  i_clock_second,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_result_kind,
    output logic [4:0]       o_set_day,
    output logic [4:0]       o_set_hour,
    output logic [5:0]       o_set_minute,
    output logic [5:0]       o_set_second,
    output logic [1:0]       o_reply_code,
    output logic [7:0]       o_reply_byte,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import tsfa_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;

    logic    fire;
    logic    res_valid;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ticks       <= WINDOW_RESET;
            r_cfg.reply_delay_ticks  <= DELAY_RESET;
            r_cfg.delta_invalid_code <= INVALID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WINDOW:  r_cfg.window_ticks       <= i_cfg_data;
                CFG_DELAY:   r_cfg.reply_delay_ticks  <= i_cfg_data[9:0];
                CFG_INVALID: r_cfg.delta_invalid_code <= i_cfg_data[7:0];
                CFG_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // processing stage moves unless a held result blocks it
    assign fire       = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_item.command      <= t_cmd'(i_command);
            r_item.param        <= i_param;
            r_item.clock_valid  <= i_clock_valid;
            r_item.clock_second <= i_clock_second;
        end
    end

    tsfa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.result_kind;
    assign o_set_day     = r_out.set_day;
    assign o_set_hour    = r_out.set_hour;
    assign o_set_minute  = r_out.set_minute;
    assign o_set_second  = r_out.set_second;
    assign o_reply_code  = r_out.reply_code;
    assign o_reply_byte  = r_out.reply_byte;

    a_stall_only_on_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled without a blocked result");

    a_set_has_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_SET) |->
            (o_reply_code == 2'd0 && o_reply_byte == 8'd0))
        else $error("clock write carries reply fields");

    a_reply_has_no_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_REPLY) |->
            (o_set_day == 5'd0 && o_set_hour == 5'd0 &&
             o_set_minute == 6'd0 && o_set_second == 6'd0))
        else $error("reply carries time fields");

    a_result_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid)) |-> $past(r_in_valid))
        else $error("result appeared with no word in the stage");

endmodule
`default_nettype wire
